// ===== rtl/psm_pkg.sv =====
`default_nettype none
package psm_pkg;

  // Divide-by-3 reciprocal: floor(x * RECIP3 >> DIV3_SHIFT) == x / 3 for x < 2^17
  localparam int unsigned DIV3_SHIFT = 18;
  localparam logic [16:0] RECIP3     = 17'd87382;

  // Number of result bits, one per square-root stage
  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned QUEUE_D = 4;

  // Remainder codes of the spread modulo 3
  localparam logic [1:0] REM_ZERO = 2'd0;
  localparam logic [1:0] REM_ONE  = 2'd1;
  localparam logic [1:0] REM_TWO  = 2'd2;

  // One square-root stage: remaining radicand bits, partial remainder, partial root
  typedef struct packed {
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } sq_t;

  // floor(r * 65536 / 3) for r = spread mod 3
  function automatic logic [15:0] third_frac(logic [1:0] r);
    logic [15:0] f;
    unique case (r)
      REM_ZERO: f = 16'd0;
      REM_ONE:  f = 16'd21845;
      REM_TWO:  f = 16'd43690;
      default:  f = 16'd0;
    endcase
    return f;
  endfunction

  // One restoring square-root step: bring down two radicand bits, try the next root bit
  function automatic sq_t sq_step(sq_t s);
    logic [19:0] cur;
    logic [19:0] trial;
    sq_t         o;
    cur   = {s.rem, s.rad[31:30]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[29:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = 18'(cur - trial);
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = cur[17:0];
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psm_pix_if.sv =====
`default_nettype none
interface psm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_first;
  logic [7:0] chan_second;
  logic [7:0] chan_third;

  modport source (output valid, output chan_first, output chan_second,
                  output chan_third, input ready);
  modport sink   (input valid, input chan_first, input chan_second,
                  input chan_third, output ready);
endinterface
`default_nettype wire

// ===== rtl/psm_sat_if.sv =====
`default_nettype none
interface psm_sat_if;
  logic        valid;
  logic        ready;
  logic [15:0] saturation;

  modport source (output valid, output saturation, input ready);
  modport sink   (input valid, input saturation, output ready);
endinterface
`default_nettype wire

// ===== rtl/psm_front.sv =====
`default_nettype none
// Front end: channel spread and the fixed-point radicand, three stages
module psm_front (
  input  wire         clk,
  input  wire         rst,
  psm_pix_if.sink     pixel,
  input  wire         q_full,
  output logic        push,
  output logic [31:0] radicand
);
  import psm_pkg::*;

  logic        v1, v2, v3;
  logic        advance;
  logic [15:0] sq_ab, sq_bc, sq_ca;
  logic [16:0] spread2;
  logic [16:0] spread3;
  logic [33:0] prod3;

  logic [8:0]  d_ab, d_bc, d_ca;
  logic [7:0]  m_ab, m_bc, m_ca;
  logic [17:0] sum_sq;
  logic [15:0] quot;
  logic [17:0] three_q;
  logic [17:0] rem_full;

  // Whole front moves together unless the last stage is blocked by a full queue
  assign advance     = !(v3 && q_full);
  assign pixel.ready = advance;
  assign push        = v3 && !q_full;

  // Pairwise channel differences; 3Q - S^2 equals the sum of their squares
  always_comb begin
    d_ab = {1'b0, pixel.chan_first}  - {1'b0, pixel.chan_second};
    d_bc = {1'b0, pixel.chan_second} - {1'b0, pixel.chan_third};
    d_ca = {1'b0, pixel.chan_third}  - {1'b0, pixel.chan_first};
    m_ab = d_ab[8] ? 8'(-d_ab) : d_ab[7:0];
    m_bc = d_bc[8] ? 8'(-d_bc) : d_bc[7:0];
    m_ca = d_ca[8] ? 8'(-d_ca) : d_ca[7:0];
    sum_sq = {2'b00, sq_ab} + {2'b00, sq_bc} + {2'b00, sq_ca};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= pixel.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Datapath: squares, sum, reciprocal multiply
  always_ff @(posedge clk) begin
    if (advance) begin
      sq_ab   <= m_ab * m_ab;
      sq_bc   <= m_bc * m_bc;
      sq_ca   <= m_ca * m_ca;
      spread2 <= sum_sq[16:0];
      spread3 <= spread2;
      prod3   <= spread2 * RECIP3;
    end
  end

  // spread*65536/3 = (spread/3)*65536 + floor((spread mod 3)*65536/3)
  always_comb begin
    quot     = prod3[DIV3_SHIFT +: 16];
    three_q  = {1'b0, quot, 1'b0} + {2'b00, quot};
    rem_full = {1'b0, spread3} - three_q;
    radicand = {quot, third_frac(rem_full[1:0])};
  end
endmodule
`default_nettype wire

// ===== rtl/psm_queue.sv =====
`default_nettype none
// Short FIFO between front and back
module psm_queue (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  wire  [31:0] wr_data,
  output logic        full,
  input  wire         pop,
  output logic        not_empty,
  output logic [31:0] rd_data
);
  import psm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_D);

  logic [31:0]      entries [QUEUE_D];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(QUEUE_D));
  assign not_empty = (count != '0);
  assign rd_data   = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== rtl/psm_back.sv =====
`default_nettype none
// Back end: 16-stage pipelined square root, one root bit per stage
module psm_back (
  input  wire        clk,
  input  wire        rst,
  input  wire        q_valid,
  input  wire [31:0] q_data,
  output logic       pop,
  psm_sat_if.source  result
);
  import psm_pkg::*;

  sq_t  stage [ROOT_W];
  logic valid [ROOT_W];
  logic advance;
  sq_t  seed;

  // Last stage is the output register; everything moves when it can be refilled
  assign advance          = !valid[ROOT_W-1] || result.ready;
  assign pop              = advance && q_valid;
  assign result.valid     = valid[ROOT_W-1];
  assign result.saturation = stage[ROOT_W-1].root;

  always_comb begin
    seed.rad  = q_data;
    seed.rem  = '0;
    seed.root = '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROOT_W; i++) valid[i] <= 1'b0;
    end else if (advance) begin
      valid[0] <= q_valid;
      for (int i = 1; i < ROOT_W; i++) valid[i] <= valid[i-1];
    end
  end

  // Root stages
  always_ff @(posedge clk) begin
    if (advance) begin
      stage[0] <= sq_step(seed);
      for (int i = 1; i < ROOT_W; i++) stage[i] <= sq_step(stage[i-1]);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pixel_saturation_map.sv =====
// Pixel saturation: per pixel, sqrt((3Q - S^2) / 3) with 8 fractional
// bits, where S is the channel sum and Q the sum of squared channels.
//
// Channels: "pixel" takes one three-channel item (8-bit unsigned channels) on
// valid && ready; "result" gives one 16-bit saturation item per pixel, in order,
// on valid && ready.
//
// Throughput: one item per cycle, sustained, as long as the receiver takes
// results. From pixel accept to result valid, an item passes three front
// stages (squares, sum, divide by three), the queue, and sixteen square-root
// stages, one result bit each, the last being the output register.
//
// Reset (synchronous, rst high) empties the pipelines and the four-entry queue;
// no item is in flight afterwards. When the receiver stalls, the root pipeline
// holds, the queue fills, and only then does the front drop pixel.ready.
`default_nettype none
module pixel_saturation_map (
  input  wire       clk,
  input  wire       rst,
  psm_pix_if.sink   pixel,
  psm_sat_if.source result
);
  import psm_pkg::*;

  logic        push;
  logic [31:0] radicand;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  logic [31:0] q_data;

  psm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .q_full   (q_full),
    .push     (push),
    .radicand (radicand)
  );

  psm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (radicand),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  psm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .result  (result)
  );
endmodule
`default_nettype wire
